// ----- sv/sct_pkg.sv -----
// Shared types, constants and control-word layout for the symbol count tree.
package sct_pkg;

  localparam int SYM_W       = 8;
  localparam int POS_W       = 32;
  localparam int OUT_W       = 32;
  localparam int TREE_LEAVES = 256;
  localparam int NODE_AW     = 9;
  localparam int STEP_W      = 4;

  typedef enum logic [1:0] {
    OP_INC  = 2'd0,
    OP_DEC  = 2'd1,
    OP_LESS = 2'd2,
    OP_FIND = 2'd3
  } op_t;

  typedef struct packed {
    op_t              operation;
    logic [SYM_W-1:0] symbol;
    logic [POS_W-1:0] position;
  } sct_in_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_out;
    logic [OUT_W-1:0] count_out;
    logic             fault;
  } sct_out_t;

  typedef logic [STEP_W-1:0] step_t;

  // read address source
  typedef enum logic [2:0] {
    RD_NODE, RD_ROOT, RD_LEAF, RD_UP, RD_SIB, RD_TWO, RD_DESC
  } rd_sel_t;

  // write at the current node
  typedef enum logic [1:0] {
    WR_NONE, WR_ZERO, WR_INC, WR_DEC
  } wr_sel_t;

  typedef enum logic [2:0] {
    ND_HOLD, ND_LEAF, ND_ROOT, ND_UP, ND_DESC, ND_INC
  } nd_sel_t;

  typedef enum logic [2:0] {
    AC_HOLD, AC_ZERO, AC_POS, AC_SUM, AC_DESC
  } acc_sel_t;

  typedef enum logic [3:0] {
    C_ALWAYS, C_DISPATCH, C_CLR_MORE, C_FULL, C_ZERO,
    C_NOT_ROOT, C_UP_MORE, C_DESC_MORE, C_OUT_FREE
  } cond_t;

  typedef struct packed {
    rd_sel_t  rd;
    wr_sel_t  wr;
    nd_sel_t  nd;
    acc_sel_t acc;
    cond_t    cond;
    logic     fault_on_zero;
    logic     accept;
    logic     finish;
    step_t    tgt_t;
    step_t    tgt_f;
  } ctl_word_t;

  typedef struct packed {
    logic start;
    op_t  op;
    logic clr_more;
    logic full;
    logic zero;
    logic not_root;
    logic up_more;
    logic desc_more;
    logic out_free;
  } sct_flags_t;

endpackage

// ----- sv/sct_seq.sv -----
// Microcode sequencer: step register, control ROM and branch logic.
module sct_seq
  import sct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  sct_flags_t flags,
  output ctl_word_t  ctl
);

  localparam step_t S_CLR   = 4'd0;
  localparam step_t S_IDLE  = 4'd1;
  localparam step_t S_INC_A = 4'd2;
  localparam step_t S_INC_B = 4'd3;
  localparam step_t S_INC_C = 4'd4;
  localparam step_t S_DEC_A = 4'd5;
  localparam step_t S_DEC_B = 4'd6;
  localparam step_t S_DEC_C = 4'd7;
  localparam step_t S_SUM_A = 4'd8;
  localparam step_t S_SUM_B = 4'd9;
  localparam step_t S_SUM_C = 4'd10;
  localparam step_t S_FND_A = 4'd11;
  localparam step_t S_FND_B = 4'd12;
  localparam step_t S_DONE  = 4'd13;

  step_t pc_r, pc_nxt;
  logic  taken;

  function automatic ctl_word_t rom(input step_t s);
    ctl_word_t w;
    w = '{rd: RD_NODE, wr: WR_NONE, nd: ND_HOLD, acc: AC_HOLD, cond: C_ALWAYS,
          fault_on_zero: 1'b0, accept: 1'b0, finish: 1'b0,
          tgt_t: S_IDLE, tgt_f: S_IDLE};
    case (s)
      S_CLR: begin
        w.wr = WR_ZERO; w.nd = ND_INC; w.cond = C_CLR_MORE;
        w.tgt_t = S_CLR; w.tgt_f = S_IDLE;
      end
      S_IDLE: begin
        w.accept = 1'b1; w.cond = C_DISPATCH;
      end
      S_INC_A: begin
        w.rd = RD_ROOT; w.nd = ND_LEAF; w.tgt_t = S_INC_B;
      end
      S_INC_B: begin
        w.cond = C_FULL; w.tgt_t = S_DONE; w.tgt_f = S_INC_C;
      end
      S_INC_C: begin
        w.rd = RD_UP; w.wr = WR_INC; w.nd = ND_UP; w.cond = C_NOT_ROOT;
        w.tgt_t = S_INC_C; w.tgt_f = S_DONE;
      end
      S_DEC_A: begin
        w.rd = RD_LEAF; w.nd = ND_LEAF; w.tgt_t = S_DEC_B;
      end
      S_DEC_B: begin
        w.cond = C_ZERO; w.fault_on_zero = 1'b1;
        w.tgt_t = S_DONE; w.tgt_f = S_DEC_C;
      end
      S_DEC_C: begin
        w.rd = RD_UP; w.wr = WR_DEC; w.nd = ND_UP; w.cond = C_NOT_ROOT;
        w.tgt_t = S_DEC_C; w.tgt_f = S_DONE;
      end
      S_SUM_A: begin
        w.nd = ND_LEAF; w.acc = AC_ZERO; w.tgt_t = S_SUM_B;
      end
      S_SUM_B: begin
        w.rd = RD_SIB; w.acc = AC_SUM; w.nd = ND_UP; w.cond = C_UP_MORE;
        w.tgt_t = S_SUM_B; w.tgt_f = S_SUM_C;
      end
      S_SUM_C: begin
        w.acc = AC_SUM; w.tgt_t = S_DONE;
      end
      S_FND_A: begin
        w.rd = RD_TWO; w.nd = ND_ROOT; w.acc = AC_POS; w.tgt_t = S_FND_B;
      end
      S_FND_B: begin
        w.rd = RD_DESC; w.nd = ND_DESC; w.acc = AC_DESC; w.cond = C_DESC_MORE;
        w.tgt_t = S_FND_B; w.tgt_f = S_DONE;
      end
      S_DONE: begin
        w.finish = 1'b1; w.cond = C_OUT_FREE;
        w.tgt_t = S_IDLE; w.tgt_f = S_DONE;
      end
      default: begin
        w.tgt_t = S_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic step_t entry(input op_t op);
    step_t s;
    case (op)
      OP_INC:  s = S_INC_A;
      OP_DEC:  s = S_DEC_A;
      OP_LESS: s = S_SUM_A;
      OP_FIND: s = S_FND_A;
      default: s = S_IDLE;
    endcase
    return s;
  endfunction

  assign ctl = rom(pc_r);

  always_comb begin
    case (ctl.cond)
      C_ALWAYS:    taken = 1'b1;
      C_DISPATCH:  taken = flags.start;
      C_CLR_MORE:  taken = flags.clr_more;
      C_FULL:      taken = flags.full;
      C_ZERO:      taken = flags.zero;
      C_NOT_ROOT:  taken = flags.not_root;
      C_UP_MORE:   taken = flags.up_more;
      C_DESC_MORE: taken = flags.desc_more;
      C_OUT_FREE:  taken = flags.out_free;
      default:     taken = 1'b1;
    endcase
    if (ctl.cond == C_DISPATCH) begin
      pc_nxt = taken ? entry(flags.op) : S_IDLE;
    end else begin
      pc_nxt = taken ? ctl.tgt_t : ctl.tgt_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_CLR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // a transaction is taken only from the idle step
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    flags.start |-> pc_r == S_IDLE)
    else $error("transaction taken outside idle step");

  // the clearing sweep never shares a cycle with a loaded result
  a_clr_no_finish: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == S_CLR |=> !(ctl.finish && $past(flags.clr_more)))
    else $error("result step reached during clearing sweep");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == S_DONE && !flags.out_free |=> pc_r == S_DONE)
    else $error("left result step while output busy");

endmodule

// ----- sv/symbol_count_tree_top.sv -----
// Top level of the symbol count tree: datapath, node memory and handshakes.
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data    | operation, symbol, position
//  result  | out_valid, out_ready, out_data | symbol_out, count_out, fault
//
// One item at a time. A transaction takes one idle step, then increment (root
// check, then a read-modify-write at each level up to the root unless the total
// is full), decrement, count smaller or find, each with one read per level on the
// node memory; the result step waits while the output register is full.
// After reset a clearing sweep writes all 512 nodes, one a cycle; in_ready
// stays low until the sweep ends. A finished result waits in the output
// register while the next transaction is already accepted.
module symbol_count_tree_top
  import sct_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sct_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sct_out_t out_data
);

  localparam int AW = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

  ctl_word_t  ctl;
  sct_flags_t flags;

  logic [COUNT_WIDTH-1:0] mem [2*TREE_LEAVES];
  logic [COUNT_WIDTH-1:0] rdata_r;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [COUNT_WIDTH-1:0] sum_w;
  logic [NODE_AW-1:0]     raddr, leaf, desc_j;
  logic [NODE_AW-1:0]     node_r, node_nxt;
  logic [AW-1:0]          acc_r, acc_nxt, left_ext;
  logic                   odd_r, odd_nxt;
  logic                   fault_r;
  logic                   desc_go, we, start, out_free, out_load, hi_nz;
  sct_in_t                item_r;
  logic                   out_valid_r;
  sct_out_t               out_data_r, result;

  sct_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  assign in_ready = ctl.accept;
  assign start    = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = ctl.finish && out_free;

  assign leaf     = {1'b1, item_r.symbol};
  assign left_ext = AW'(rdata_r);
  assign desc_go  = left_ext >= acc_r;
  assign desc_j   = {node_r[NODE_AW-2:0], !desc_go};
  assign sum_w    = acc_r[COUNT_WIDTH-1:0] + (odd_r ? rdata_r : '0);
  assign we       = ctl.wr != WR_NONE;

  assign flags = '{start:     start,
                   op:        in_data.operation,
                   clr_more:  node_r != '1,
                   full:      rdata_r == '1,
                   zero:      rdata_r == '0,
                   not_root:  node_r[NODE_AW-1:1] != '0,
                   up_more:   node_r[NODE_AW-1:2] != '0,
                   desc_more: !desc_j[NODE_AW-1],
                   out_free:  out_free};

  always_comb begin
    case (ctl.rd)
      RD_NODE: raddr = node_r;
      RD_ROOT: raddr = NODE_AW'(1);
      RD_LEAF: raddr = leaf;
      RD_UP:   raddr = node_r >> 1;
      RD_SIB:  raddr = node_r - NODE_AW'(1);
      RD_TWO:  raddr = NODE_AW'(2);
      RD_DESC: raddr = {desc_j[NODE_AW-2:0], 1'b0};
      default: raddr = node_r;
    endcase

    case (ctl.wr)
      WR_ZERO: wdata = '0;
      WR_INC:  wdata = rdata_r + COUNT_WIDTH'(1);
      WR_DEC:  wdata = rdata_r - COUNT_WIDTH'(1);
      default: wdata = rdata_r;
    endcase

    odd_nxt = odd_r;
    case (ctl.nd)
      ND_LEAF: begin
        node_nxt = leaf;
        odd_nxt  = 1'b0;
      end
      ND_ROOT: node_nxt = NODE_AW'(1);
      ND_UP: begin
        node_nxt = node_r >> 1;
        odd_nxt  = node_r[0];
      end
      ND_DESC: node_nxt = desc_j;
      ND_INC:  node_nxt = node_r + NODE_AW'(1);
      default: node_nxt = node_r;
    endcase

    case (ctl.acc)
      AC_ZERO: acc_nxt = '0;
      AC_POS:  acc_nxt = AW'(item_r.position);
      AC_SUM:  acc_nxt = AW'(sum_w);
      AC_DESC: acc_nxt = desc_go ? acc_r : acc_r - left_ext;
      default: acc_nxt = acc_r;
    endcase
  end

  // saturate counts wider than the output field
  assign hi_nz = (acc_r >> OUT_W) != '0;

  always_comb begin
    result.fault = fault_r;
    if (item_r.operation == OP_FIND) begin
      result.symbol_out = node_r[SYM_W-1:0];
    end else begin
      result.symbol_out = item_r.symbol;
    end
    if (item_r.operation == OP_LESS || item_r.operation == OP_FIND) begin
      result.count_out = hi_nz ? '1 : acc_r[OUT_W-1:0];
    end else begin
      result.count_out = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[node_r] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r      <= '0;
      out_valid_r <= 1'b0;
      fault_r     <= 1'b0;
    end else begin
      node_r <= node_nxt;
      if (start) begin
        fault_r <= 1'b0;
      end else if (ctl.fault_on_zero && flags.zero) begin
        fault_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    odd_r <= odd_nxt;
    if (start) begin
      item_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one is in flight");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish && out_valid_r && !out_ready |=> $stable(out_data_r))
    else $error("pending result overwritten");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> !in_ready)
    else $error("node write while idle");

  a_fault_dec_only: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |-> item_r.operation == OP_DEC)
    else $error("fault raised outside decrement");

endmodule
